>>> rtl/gso_pkg.sv
// Shared types, constants and helpers for the 4D Gram-Schmidt block.
// No dependencies; the top, lane, merge and bench checker files refer to it by scoped names.
package gso_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int ROWS      = 3;
  // Quotient bits of the per-lane divider and width of its dividend.
  localparam int QB        = FRAC_BITS + 2;
  localparam int DW        = FRAC_BITS + 32;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W     = 6;
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QB - 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] NEG_CLAMP = -32'sd2147483647;

  typedef enum logic [3:0] {
    S_IDLE, S_MULV, S_PROJ, S_MULP, S_UPD, S_CLAMP, S_MAX, S_SHIFT,
    S_SQR, S_LEN2, S_SQRT, S_DIVINIT, S_DIV, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    LOP_NONE, LOP_LOAD, LOP_MUL_V, LOP_MUL_P, LOP_UPD, LOP_CLAMP, LOP_SHL,
    LOP_SQR, LOP_DIVINIT, LOP_DIVSTEP
  } lane_op_e;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_PROJ, MOP_MAX, MOP_SHL, MOP_LEN2, MOP_SQRT
  } merge_op_e;

  typedef struct packed {
    lane_op_e           op;
    logic signed [31:0] proj;
    logic [31:0]        len;
  } lane_ctl_t;

  typedef struct packed {
    merge_op_e op;
  } merge_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Round to nearest on the fraction, ties toward plus infinity.
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + HALF;
    return t >>> FRAC_BITS;
  endfunction

endpackage

>>> rtl/gso_col_if.sv
// Input channel: one basis column per item, valid/ready handshake.
// Depends on nothing.
interface gso_col_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] col_x;
  logic signed [31:0] col_y;
  logic signed [31:0] col_z;
  logic signed [31:0] col_w;

  modport source (output valid, col_x, col_y, col_z, col_w, input ready);
  modport sink   (input valid, col_x, col_y, col_z, col_w, output ready);
  modport mon    (input valid, ready, col_x, col_y, col_z, col_w);
endinterface

>>> rtl/gso_unit_if.sv
// Output channel: one orthonormalized column per item, valid/ready handshake.
// Depends on nothing.
interface gso_unit_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic signed [31:0] unit_w;
  logic [1:0]         column_index;
  logic               last_column;
  logic               zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, column_index,
                  last_column, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, column_index,
                  last_column, zero_length, output ready);
  modport mon    (input valid, ready, unit_x, unit_y, unit_z, unit_w,
                  column_index, last_column, zero_length);
endinterface

>>> rtl/gram_schmidt_orthonormalize_4d_top.sv
// Modified Gram-Schmidt orthonormalization of a 4x4 basis, one column per item.
// Column channel col_i (sink), result channel unit_o (source), valid/ready.
//
// Columns arrive in order 0..3; the block keeps a column counter and the first
// three emitted columns, and wraps to a new basis after column 3.
// One item at a time: after an item is taken, ready stays low until its result
// has been moved into the output register. Per column the block projects out
// each stored column, clamps, normalizes by a shift s (0..30), sums squares,
// takes the 32-step square root in the merge stage and runs the QB-step lane
// dividers, with QB = FRAC_BITS + 2.
// A zero residual skips root and divide and returns a zero column with
// zero_length set.
// Reset clears the counter, the state machine and the output valid; the
// stored columns need no reset since each is written before it is read.
// The output register holds a result while the receiver stalls; the next
// item may be accepted and worked on meanwhile, and waits at its end.
module gram_schmidt_orthonormalize_4d_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  gso_col_if.sink    col_i,
  gso_unit_if.source unit_o
);

  gso_pkg::state_e      state_q, state_d;
  logic [1:0]           count_q, count_d;
  logic [1:0]           j_q, j_d;
  logic [gso_pkg::CNT_W-1:0] step_q, step_d;
  logic                 zero_q, zero_d;
  logic                 ovalid_q, ovalid_d;
  logic                 emit;

  logic signed [31:0]   basis_q [gso_pkg::ROWS][gso_pkg::LANES];
  logic signed [31:0]   ux_q, uy_q, uz_q, uw_q;
  logic [1:0]           oidx_q;
  logic                 olast_q, ozero_q;

  gso_pkg::lane_op_e    lop;
  gso_pkg::lane_ctl_t   lctl;
  gso_pkg::merge_ctl_t  mctl;
  logic signed [31:0]   load  [gso_pkg::LANES];
  logic signed [63:0]   rnd   [gso_pkg::LANES];
  logic [30:0]          absv  [gso_pkg::LANES];
  logic [63:0]          sq    [gso_pkg::LANES];
  logic signed [31:0]   unit  [gso_pkg::LANES];
  logic signed [31:0]   res   [gso_pkg::LANES];
  logic signed [31:0]   proj;
  logic [30:0]          maxv;
  logic [31:0]          len;

  assign load[0] = col_i.col_x;
  assign load[1] = col_i.col_y;
  assign load[2] = col_i.col_z;
  assign load[3] = col_i.col_w;

  assign lctl = '{op: lop, proj: proj, len: len};

  for (genvar k = 0; k < gso_pkg::LANES; k++) begin : g_lane
    gso_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lctl),
      .load_i (load[k]),
      .u_i    (basis_q[j_q][k]),
      .rnd_o  (rnd[k]),
      .abs_o  (absv[k]),
      .sq_o   (sq[k]),
      .unit_o (unit[k])
    );
    assign res[k] = zero_q ? 32'sd0 : unit[k];
  end

  gso_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .rnd_i  (rnd),
    .abs_i  (absv),
    .sq_i   (sq),
    .proj_o (proj),
    .max_o  (maxv),
    .len_o  (len)
  );

  assign col_i.ready = (state_q == gso_pkg::S_IDLE);
  assign emit = (state_q == gso_pkg::S_EMIT) && (!ovalid_q || unit_o.ready);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    j_d      = j_q;
    step_d   = step_q;
    zero_d   = zero_q;
    ovalid_d = ovalid_q;
    lop      = gso_pkg::LOP_NONE;
    mctl.op  = gso_pkg::MOP_NONE;
    if (ovalid_q && unit_o.ready) ovalid_d = 1'b0;
    case (state_q)
      gso_pkg::S_IDLE: begin
        if (col_i.valid) begin
          lop     = gso_pkg::LOP_LOAD;
          j_d     = '0;
          zero_d  = 1'b0;
          state_d = (count_q == 2'd0) ? gso_pkg::S_CLAMP : gso_pkg::S_MULV;
        end
      end
      gso_pkg::S_MULV: begin
        lop     = gso_pkg::LOP_MUL_V;
        state_d = gso_pkg::S_PROJ;
      end
      gso_pkg::S_PROJ: begin
        mctl.op = gso_pkg::MOP_PROJ;
        state_d = gso_pkg::S_MULP;
      end
      gso_pkg::S_MULP: begin
        lop     = gso_pkg::LOP_MUL_P;
        state_d = gso_pkg::S_UPD;
      end
      gso_pkg::S_UPD: begin
        lop     = gso_pkg::LOP_UPD;
        j_d     = j_q + 2'd1;
        state_d = (j_q + 2'd1 == count_q) ? gso_pkg::S_CLAMP : gso_pkg::S_MULV;
      end
      gso_pkg::S_CLAMP: begin
        lop     = gso_pkg::LOP_CLAMP;
        state_d = gso_pkg::S_MAX;
      end
      gso_pkg::S_MAX: begin
        mctl.op = gso_pkg::MOP_MAX;
        state_d = gso_pkg::S_SHIFT;
      end
      gso_pkg::S_SHIFT: begin
        if (maxv == '0) begin
          zero_d  = 1'b1;
          state_d = gso_pkg::S_EMIT;
        end else if (!maxv[30]) begin
          // normalize: shift until the largest magnitude reaches 2^30
          lop     = gso_pkg::LOP_SHL;
          mctl.op = gso_pkg::MOP_SHL;
        end else begin
          state_d = gso_pkg::S_SQR;
        end
      end
      gso_pkg::S_SQR: begin
        lop     = gso_pkg::LOP_SQR;
        state_d = gso_pkg::S_LEN2;
      end
      gso_pkg::S_LEN2: begin
        mctl.op = gso_pkg::MOP_LEN2;
        step_d  = '0;
        state_d = gso_pkg::S_SQRT;
      end
      gso_pkg::S_SQRT: begin
        mctl.op = gso_pkg::MOP_SQRT;
        step_d  = step_q + 1'b1;
        if (step_q == gso_pkg::SQRT_LAST) state_d = gso_pkg::S_DIVINIT;
      end
      gso_pkg::S_DIVINIT: begin
        lop     = gso_pkg::LOP_DIVINIT;
        step_d  = '0;
        state_d = gso_pkg::S_DIV;
      end
      gso_pkg::S_DIV: begin
        lop     = gso_pkg::LOP_DIVSTEP;
        step_d  = step_q + 1'b1;
        if (step_q == gso_pkg::DIV_LAST) state_d = gso_pkg::S_EMIT;
      end
      gso_pkg::S_EMIT: begin
        // hold here while the output register is still full
        if (emit) begin
          ovalid_d = 1'b1;
          count_d  = count_q + 2'd1;
          state_d  = gso_pkg::S_IDLE;
        end
      end
      default: state_d = gso_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gso_pkg::S_IDLE;
      count_q  <= '0;
      j_q      <= '0;
      step_q   <= '0;
      zero_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      j_q      <= j_d;
      step_q   <= step_d;
      zero_q   <= zero_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ux_q    <= res[0];
      uy_q    <= res[1];
      uz_q    <= res[2];
      uw_q    <= res[3];
      oidx_q  <= count_q;
      olast_q <= (count_q == 2'd3);
      ozero_q <= zero_q;
      if (count_q != 2'd3) begin
        for (int k = 0; k < gso_pkg::LANES; k++) basis_q[count_q][k] <= res[k];
      end
    end
  end

  assign unit_o.valid        = ovalid_q;
  assign unit_o.unit_x       = ux_q;
  assign unit_o.unit_y       = uy_q;
  assign unit_o.unit_z       = uz_q;
  assign unit_o.unit_w       = uw_q;
  assign unit_o.column_index = oidx_q;
  assign unit_o.last_column  = olast_q;
  assign unit_o.zero_length  = ozero_q;

endmodule

>>> rtl/gso_lane.sv
// One element lane: multiplier, residual update, normalize shift and divider.
// Depends on gso_pkg.
module gso_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gso_pkg::lane_ctl_t        ctl_i,
  input  logic signed [31:0]        load_i,
  input  logic signed [31:0]        u_i,
  output logic signed [63:0]        rnd_o,
  output logic [30:0]               abs_o,
  output logic [63:0]               sq_o,
  output logic signed [31:0]        unit_o
);

  logic signed [31:0]       v_q, v_d;
  logic signed [63:0]       prod_q, prod_d;
  logic [32:0]              rem_q, rem_d;
  logic [gso_pkg::QB-1:0]   sh_q, sh_d;
  logic [gso_pkg::QB-1:0]   quo_q, quo_d;
  logic                     neg_q, neg_d;

  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       diff;
  logic [31:0]              mag;
  logic [gso_pkg::DW-1:0]   dvd;
  logic [33:0]              trial;

  assign rnd_o = gso_pkg::round_frac(prod_q);
  assign abs_o = v_q[31] ? 31'(-v_q) : v_q[30:0];
  assign sq_o  = prod_q;
  assign unit_o = neg_q ? -(32'(quo_q)) : 32'(quo_q);

  always_comb begin
    mul_a = v_q;
    mul_b = u_i;
    case (ctl_i.op)
      gso_pkg::LOP_MUL_P: mul_a = ctl_i.proj;
      gso_pkg::LOP_SQR:   mul_b = v_q;
      default: ;
    endcase
  end

  always_comb begin
    v_d    = v_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    diff   = 64'(v_q) - gso_pkg::round_frac(prod_q);
    mag    = v_q[31] ? 32'(-v_q) : 32'(v_q);
    dvd    = (gso_pkg::DW'(mag) << gso_pkg::FRAC_BITS) + gso_pkg::DW'(ctl_i.len >> 1);
    trial  = {rem_q, sh_q[gso_pkg::QB-1]};
    case (ctl_i.op)
      gso_pkg::LOP_LOAD:  v_d = load_i;
      gso_pkg::LOP_MUL_V,
      gso_pkg::LOP_MUL_P,
      gso_pkg::LOP_SQR:   prod_d = mul_a * mul_b;
      gso_pkg::LOP_UPD:   v_d = gso_pkg::sat32(diff);
      gso_pkg::LOP_CLAMP: if (v_q < gso_pkg::NEG_CLAMP) v_d = gso_pkg::NEG_CLAMP;
      gso_pkg::LOP_SHL:   v_d = v_q <<< 1;
      gso_pkg::LOP_DIVINIT: begin
        rem_d = 33'(dvd[gso_pkg::DW-1:gso_pkg::QB]);
        sh_d  = dvd[gso_pkg::QB-1:0];
        quo_d = '0;
        neg_d = v_q[31];
      end
      gso_pkg::LOP_DIVSTEP: begin
        // restoring step: one quotient bit per cycle
        if (trial >= {2'b00, ctl_i.len}) begin
          rem_d = 33'(trial - {2'b00, ctl_i.len});
          quo_d = {quo_q[gso_pkg::QB-2:0], 1'b1};
        end else begin
          rem_d = trial[32:0];
          quo_d = {quo_q[gso_pkg::QB-2:0], 1'b0};
        end
        sh_d = sh_q << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else begin
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    quo_q  <= quo_d;
  end

endmodule

>>> rtl/gso_merge.sv
// Merging stage: projection sum, largest magnitude, sum of squares and the
// bit-serial square root of that sum. Depends on gso_pkg.
module gso_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gso_pkg::merge_ctl_t ctl_i,
  input  logic signed [63:0]  rnd_i [gso_pkg::LANES],
  input  logic [30:0]         abs_i [gso_pkg::LANES],
  input  logic [63:0]         sq_i  [gso_pkg::LANES],
  output logic signed [31:0]  proj_o,
  output logic [30:0]         max_o,
  output logic [31:0]         len_o
);

  logic signed [31:0] proj_q, proj_d;
  logic [30:0]        max_q, max_d;
  logic [63:0]        n_q, n_d;
  logic [33:0]        rem_q, rem_d;
  logic [31:0]        root_q, root_d;
  logic               busy_q;

  logic signed [63:0] psum;
  logic [30:0]        mx;
  logic [63:0]        ssum;
  logic [35:0]        t;
  logic [35:0]        trial;

  assign proj_o = proj_q;
  assign max_o  = max_q;
  assign len_o  = root_q;

  always_comb begin
    psum = '0;
    mx   = '0;
    ssum = '0;
    for (int k = 0; k < gso_pkg::LANES; k++) begin
      psum = psum + rnd_i[k];
      ssum = ssum + sq_i[k];
      if (abs_i[k] > mx) mx = abs_i[k];
    end
    t     = {rem_q, n_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
  end

  always_comb begin
    proj_d = proj_q;
    max_d  = max_q;
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    case (ctl_i.op)
      gso_pkg::MOP_PROJ: proj_d = gso_pkg::sat32(psum);
      gso_pkg::MOP_MAX:  max_d = mx;
      gso_pkg::MOP_SHL:  max_d = max_q << 1;
      gso_pkg::MOP_LEN2: begin
        n_d    = ssum;
        rem_d  = '0;
        root_d = '0;
      end
      gso_pkg::MOP_SQRT: begin
        // take two radicand bits, try root*4+1
        if (t >= trial) begin
          rem_d  = 34'(t - trial);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = t[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
        n_d = n_q << 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= (ctl_i.op != gso_pkg::MOP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    proj_q <= proj_d;
    max_q  <= busy_q ? max_d : max_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

>>> rtl/gso_checker.sv
// Port-level checks for the Gram-Schmidt top level, bound to every instance.
// Depends only on the signals of the top level's two channels.
module gso_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        col_valid_i,
  input logic        col_ready_i,
  input logic        unit_valid_i,
  input logic        unit_ready_i,
  input logic [31:0] unit_x_i,
  input logic [31:0] unit_y_i,
  input logic [31:0] unit_z_i,
  input logic [31:0] unit_w_i,
  input logic [1:0]  column_index_i,
  input logic        last_column_i,
  input logic        zero_length_i
);

  // A stalled result keeps its valid, its x element and its column index.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_i && !unit_ready_i |=> unit_valid_i && $stable(unit_x_i)
      && $stable(column_index_i))
    else $error("result dropped or changed while stalled");

  // One column at a time: no second item right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_valid_i && col_ready_i |=> !col_ready_i)
    else $error("input taken while a column is in work");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_i |-> (last_column_i == (column_index_i == 2'd3)))
    else $error("last flag does not match column index");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_i && zero_length_i |-> unit_x_i == 0 && unit_y_i == 0
      && unit_z_i == 0 && unit_w_i == 0)
    else $error("zero-length result with nonzero elements");

endmodule

bind gram_schmidt_orthonormalize_4d_top gso_port_checker u_gso_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .col_valid_i    (col_i.valid),
  .col_ready_i    (col_i.ready),
  .unit_valid_i   (unit_o.valid),
  .unit_ready_i   (unit_o.ready),
  .unit_x_i       (unit_o.unit_x),
  .unit_y_i       (unit_o.unit_y),
  .unit_z_i       (unit_o.unit_z),
  .unit_w_i       (unit_o.unit_w),
  .column_index_i (unit_o.column_index),
  .last_column_i  (unit_o.last_column),
  .zero_length_i  (unit_o.zero_length)
);

>>> bench/gso_checker.sv
// Watches both channels of the Gram-Schmidt block, predicts each output column
// and compares it field by field. Depends on gso_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module gso_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  gso_col_if.mon    col_i,
  gso_unit_if.mon   unit_i,
  output int        errors_o,
  output int        pending_o
);

  localparam logic [1:0] LAST_COL = 2'd3;
  localparam int         FB       = gso_pkg::FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [1:0]         idx;
    logic               last;
    logic               zero;
  } unit_col_t;

  logic signed [31:0] ortho_cols [3][4];
  logic [1:0]         col_count;
  unit_col_t          expected_cols [$];

  function automatic logic signed [63:0] clip32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // Round to nearest on the fraction, ties upward (floor of p + half).
  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (FB - 1));
    return t >>> FB;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n_in);
    logic [63:0] n, r, b;
    n = n_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Orthonormalize one column against the stored ones; update the store.
  function automatic unit_col_t orthonormalize(input logic signed [31:0] c [4]);
    logic signed [63:0] v [4];
    logic signed [63:0] u [4];
    logic signed [63:0] acc, proj, m, a, num, q;
    logic [63:0]        len2, len, mag;
    int                 s;
    unit_col_t          r;
    for (int k = 0; k < 4; k++) v[k] = c[k];
    for (int j = 0; j < col_count; j++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += rnd(v[k] * ortho_cols[j][k]);
      proj = clip32(acc);
      for (int k = 0; k < 4; k++) v[k] = clip32(v[k] - rnd(proj * ortho_cols[j][k]));
    end
    m = 0;
    for (int k = 0; k < 4; k++) begin
      if (v[k] < -64'sd2147483647) v[k] = -64'sd2147483647;
      a = v[k] < 0 ? -v[k] : v[k];
      if (a > m) m = a;
    end
    r.zero = (m == 0);
    if (r.zero) begin
      for (int k = 0; k < 4; k++) u[k] = 0;
    end else begin
      s = 0;
      while (m < (64'sd1 <<< 30)) begin
        m = m * 2;
        s++;
      end
      len2 = 0;
      for (int k = 0; k < 4; k++) begin
        v[k] = v[k] <<< s;
        len2 += v[k] * v[k];
      end
      len = root64(len2);
      for (int k = 0; k < 4; k++) begin
        num = v[k] <<< FB;
        mag = num < 0 ? -num : num;
        q   = (mag + len / 2) / len;
        u[k] = clip32(num < 0 ? -q : q);
      end
    end
    if (col_count != LAST_COL)
      for (int k = 0; k < 4; k++) ortho_cols[col_count][k] = u[k][31:0];
    r.x    = u[0][31:0];
    r.y    = u[1][31:0];
    r.z    = u[2][31:0];
    r.w    = u[3][31:0];
    r.idx  = col_count;
    r.last = (col_count == LAST_COL);
    col_count = col_count + 2'd1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] c [4];
    unit_col_t got, exp_col;
    if (!rst_ni) begin
      col_count <= '0;
      errors_o  <= 0;
      expected_cols.delete();
    end else begin
      if (col_i.valid && col_i.ready) begin
        c[0] = col_i.col_x;
        c[1] = col_i.col_y;
        c[2] = col_i.col_z;
        c[3] = col_i.col_w;
        expected_cols.push_back(orthonormalize(c));
      end
      if (unit_i.valid && unit_i.ready) begin
        got = '{unit_i.unit_x, unit_i.unit_y, unit_i.unit_z, unit_i.unit_w,
                unit_i.column_index, unit_i.last_column, unit_i.zero_length};
        if (expected_cols.size() == 0) begin
          if (errors_o < 10) $display("unexpected output column %p", got);
          errors_o <= errors_o + 1;
        end else begin
          exp_col = expected_cols.pop_front();
          if (got !== exp_col) begin
            if (errors_o < 10)
              $display("mismatch: expected %p got %p", exp_col, got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_cols.size();

endmodule

>>> bench/tb_gram_schmidt_orthonormalize_4d_top.sv
// Stimulus and verdict for the Gram-Schmidt block: directed bases, then random
// ones under three idling mixes. Depends on gso_pkg, the interfaces and gso_checker.
`timescale 1ns / 1ps

module tb_gram_schmidt_orthonormalize_4d_top;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   tx_idle, rx_idle;

  gso_col_if  col_ch ();
  gso_unit_if unit_ch ();

  gram_schmidt_orthonormalize_4d_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .col_i (col_ch.sink),
    .unit_o(unit_ch.source)
  );

  gso_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .col_i    (col_ch.mon),
    .unit_i   (unit_ch.mon),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    col_ch.valid  = 1'b0;
    col_ch.col_x  = '0;
    col_ch.col_y  = '0;
    col_ch.col_z  = '0;
    col_ch.col_w  = '0;
    unit_ch.ready = 1'b0;
  end

  always @(posedge clk_i) unit_ch.ready <= ($urandom_range(99) >= rx_idle);

  // Hold the item until the block takes it; valid stays up for the caller.
  task automatic send_column(input logic [31:0] x, y, z, w);
    while ($urandom_range(99) < tx_idle) begin
      col_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    col_ch.valid <= 1'b1;
    col_ch.col_x <= x;
    col_ch.col_y <= y;
    col_ch.col_z <= z;
    col_ch.col_w <= w;
    forever begin
      @(negedge clk_i);
      if (col_ch.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
      2:       return 32'($signed($urandom_range(512)) - 256);
      default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
    endcase
  endfunction

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7fff_ffff;
  localparam logic [31:0] NMAX = 32'h8000_0000;

  initial begin
    logic [31:0] a, b, c, d;
    tx_idle = 0;
    rx_idle = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity basis
    send_column(ONE, 0, 0, 0);
    send_column(0, ONE, 0, 0);
    send_column(0, 0, ONE, 0);
    send_column(0, 0, 0, ONE);
    // zero columns and a repeated column
    send_column(0, 0, 0, 0);
    send_column(ONE, ONE, 0, 0);
    send_column(ONE, ONE, 0, 0);
    send_column(0, 0, 0, 0);
    // extremes, saturation and the most negative value
    send_column(PMAX, PMAX, PMAX, PMAX);
    send_column(NMAX, NMAX, NMAX, NMAX);
    send_column(PMAX, NMAX, PMAX, NMAX);
    send_column(NMAX, 0, PMAX, 1);
    // tiny values with large normalize shifts
    send_column(1, 0, 0, 0);
    send_column(32'hffffffff, 1, 0, 0);
    send_column(0, 0, 1, 32'hffffffff);
    send_column(2, 3, 5, 7);
    // nearly dependent columns
    send_column(ONE, 2 * ONE, 3 * ONE, 4 * ONE);
    send_column(ONE + 1, 2 * ONE, 3 * ONE, 4 * ONE);
    send_column(0, ONE, 0, 0);
    send_column(PMAX, 0, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = ph == 0 ? 33 : ph == 1 ? 58 : 0;
      rx_idle = ph == 0 ? 58 : ph == 1 ? 33 : 0;
      for (int n = 0; n < 400; n++) begin
        a = rand_elem();
        b = rand_elem();
        c = rand_elem();
        d = rand_elem();
        // a column now and then that repeats or zeroes out
        case ($urandom_range(19))
          0:       send_column(0, 0, 0, 0);
          1:       send_column(a, a, a, a);
          default: send_column(a, b, c, d);
        endcase
      end
    end
    col_ch.valid <= 1'b0;

    // let the checker record the last accepted item first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
